FILE: rtl/kwtm_pkg.sv
// shared types and constants of the keyword table matcher
`timescale 1ns / 1ps
`default_nettype none

package kwtm_pkg;

	// default table geometry
	localparam int MAX_KEYWORDS_DEF = 64;
	localparam int TOKEN_CHARS_DEF  = 64;

	// fixed field widths
	localparam int ENTRY_W = 6;
	localparam int POS_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int COUNT_W = 7;
	localparam int SUM_W   = 16;
	localparam int INDEX_W = 6;

	// entry index is six bits wide, so no more sum slots can ever be written
	localparam int SUM_DEPTH_CAP = 64;

	// depth of the queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;

	// item kinds
	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_TOKEN = 1'b1
	} op_t;

	// control bits of one queued item
	typedef struct packed {
		op_t  op;
		logic first;  // load at position zero restarts the entry sum
		logic store;  // token char is nonzero and goes to the token store
		logic last;   // final token char, starts the search
	} item_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/kwtm_front.sv
// front part: accepts items, drops no-op items, folds case and forms addresses
`timescale 1ns / 1ps
`default_nettype none

module kwtm_front #(
	parameter int MAX_KEYWORDS = kwtm_pkg::MAX_KEYWORDS_DEF,
	parameter int TOKEN_CHARS  = kwtm_pkg::TOKEN_CHARS_DEF,
	parameter int KAW          = 12,
	parameter int SAW          = 6
) (
	input  wire logic                         s_valid,
	output logic                              s_ready,
	input  wire logic                         command,
	input  wire logic [kwtm_pkg::ENTRY_W-1:0] entry_index,
	input  wire logic [kwtm_pkg::POS_W-1:0]   char_position,
	input  wire logic [kwtm_pkg::CHAR_W-1:0]  char_value,
	input  wire logic                         token_last,
	input  wire logic                         q_full,
	output logic                              q_push,
	output kwtm_pkg::item_ctl_t               q_ctl,
	output logic [KAW-1:0]                    q_addr,
	output logic [SAW-1:0]                    q_sidx,
	output logic [kwtm_pkg::CHAR_W-1:0]       q_char
);

	localparam int STRIDE = TOKEN_CHARS + 1;

	localparam logic [kwtm_pkg::CHAR_W-1:0] LOWER_A    = 8'h61;
	localparam logic [kwtm_pkg::CHAR_W-1:0] LOWER_Z    = 8'h7a;
	localparam logic [kwtm_pkg::CHAR_W-1:0] CASE_DELTA = 8'h20;

	function automatic logic [kwtm_pkg::CHAR_W-1:0] fold_upper(
		input logic [kwtm_pkg::CHAR_W-1:0] c
	);
		if (c >= LOWER_A && c <= LOWER_Z) begin
			return c - CASE_DELTA;
		end
		return c;
	endfunction

	logic accept;
	logic keep;
	logic in_range;

	assign s_ready = !q_full;
	assign accept  = s_valid && s_ready;

	// loads outside the table are ignored
	assign in_range = (32'(entry_index) < 32'(MAX_KEYWORDS)) &&
	                  (32'(char_position) <= 32'(TOKEN_CHARS));

	// classify the item
	always_comb begin
		q_ctl.op    = kwtm_pkg::op_t'(command);
		q_ctl.first = (char_position == '0);
		q_ctl.store = (char_value != kwtm_pkg::CHAR_NUL);
		q_ctl.last  = token_last;
		q_char      = char_value;
		keep        = 1'b0;
		unique case (kwtm_pkg::op_t'(command))
			kwtm_pkg::OP_LOAD: begin
				keep = in_range;
			end
			kwtm_pkg::OP_TOKEN: begin
				// a zero char that ends nothing has no effect
				keep   = (char_value != kwtm_pkg::CHAR_NUL) || token_last;
				q_char = fold_upper(char_value);
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	// keyword byte address and sum slot of a load
	assign q_addr = KAW'(32'(entry_index) * 32'(STRIDE) + 32'(char_position));
	assign q_sidx = SAW'(entry_index);

	assign q_push = accept && keep;

endmodule

`default_nettype wire

FILE: rtl/kwtm_queue.sv
// short item queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module kwtm_queue #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      pop_data,
	output logic                  empty
);

	localparam int DEPTH = kwtm_pkg::QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/kwtm_back.sv
// back part: keyword and token stores, sums, table search and result register
`timescale 1ns / 1ps
`default_nettype none

module kwtm_back #(
	parameter int MAX_KEYWORDS = kwtm_pkg::MAX_KEYWORDS_DEF,
	parameter int TOKEN_CHARS  = kwtm_pkg::TOKEN_CHARS_DEF,
	parameter int KAW          = 12,
	parameter int SAW          = 6,
	parameter int SUM_DEPTH    = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [kwtm_pkg::COUNT_W-1:0] keyword_count,
	input  wire logic                         q_empty,
	output logic                              q_pop,
	input  wire kwtm_pkg::item_ctl_t          q_ctl,
	input  wire logic [KAW-1:0]               q_addr,
	input  wire logic [SAW-1:0]               q_sidx,
	input  wire logic [kwtm_pkg::CHAR_W-1:0]  q_char,
	output logic                              m_valid,
	input  wire logic                         m_ready,
	output logic                              m_found,
	output logic [kwtm_pkg::INDEX_W-1:0]      m_index
);

	localparam int STRIDE   = TOKEN_CHARS + 1;
	localparam int KW_DEPTH = MAX_KEYWORDS * STRIDE;
	localparam int TAW      = $clog2(TOKEN_CHARS);
	localparam int LW       = $clog2(TOKEN_CHARS + 1);
	localparam int EW       = $clog2(MAX_KEYWORDS + 1);
	localparam int LIM_W    = (EW > kwtm_pkg::COUNT_W) ? EW : kwtm_pkg::COUNT_W;
	localparam int SUM_W    = kwtm_pkg::SUM_W;
	localparam int CHAR_W   = kwtm_pkg::CHAR_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_ADD,
		ST_SEARCH,
		ST_SUM_CHK,
		ST_BYTE_RD,
		ST_BYTE_CHK,
		ST_EMIT
	} state_t;

	state_t state_q;

	// stores
	logic [CHAR_W-1:0] kw_mem  [KW_DEPTH];
	logic [SUM_W-1:0]  sum_mem [SUM_DEPTH];
	logic [CHAR_W-1:0] tok_mem [TOKEN_CHARS];
	logic [SUM_DEPTH-1:0] sum_valid_q;

	logic [CHAR_W-1:0] kw_rd_q;
	logic [SUM_W-1:0]  sum_rd_q;
	logic [CHAR_W-1:0] tok_rd_q;

	// token accumulation
	logic [LW-1:0]    tok_len_q;
	logic [SUM_W-1:0] tok_sum_q;

	// load in progress
	logic [SAW-1:0]    cur_sidx_q;
	logic [CHAR_W-1:0] cur_char_q;

	// search walk
	logic [EW-1:0]  e_q;
	logic [EW-1:0]  limit_q;
	logic [KAW-1:0] base_q;
	logic [LW-1:0]  i_q;
	logic           res_found_q;
	logic [kwtm_pkg::INDEX_W-1:0] res_idx_q;

	// result register
	logic                         out_valid_q;
	logic                         out_found_q;
	logic [kwtm_pkg::INDEX_W-1:0] out_idx_q;

	logic             take;
	logic             is_load;
	logic             kw_we;
	logic             tok_we;
	logic             sum_we;
	logic [SAW-1:0]   sum_wr_idx;
	logic [SUM_W-1:0] sum_wr_data;
	logic [SAW-1:0]   sum_rd_idx;
	logic [KAW-1:0]   kw_rd_addr;
	logic [LIM_W-1:0] e_ext;
	logic [LIM_W-1:0] count_ext;
	logic [LIM_W-1:0] limit_ext;
	logic [SAW-1:0]   e_sidx;
	logic             e_has_sum;
	logic [SUM_W-1:0] entry_sum;
	logic [SUM_W-1:0] load_base;
	logic             tok_room;
	logic             out_free;

	assign take    = (state_q == ST_IDLE) && !q_empty;
	assign q_pop   = take;
	assign is_load = (q_ctl.op == kwtm_pkg::OP_LOAD);

	assign tok_room = (tok_len_q < LW'(TOKEN_CHARS));
	assign out_free = !out_valid_q || m_ready;

	// effective search limit
	assign count_ext = LIM_W'(keyword_count);
	assign limit_ext = (count_ext < LIM_W'(MAX_KEYWORDS)) ? count_ext : LIM_W'(MAX_KEYWORDS);

	// sum slot of the entry under test; slots past the last sum slot read as zero
	assign e_ext     = LIM_W'(e_q);
	assign e_sidx    = e_ext[SAW-1:0];
	assign e_has_sum = (e_ext < LIM_W'(SUM_DEPTH)) && sum_valid_q[e_sidx];
	assign entry_sum = e_has_sum ? sum_rd_q : '0;

	// keyword byte store
	assign kw_we      = take && is_load;
	assign kw_rd_addr = base_q + KAW'(i_q);

	always_ff @(posedge clk) begin
		if (kw_we) begin
			kw_mem[q_addr] <= q_char;
		end
		kw_rd_q <= kw_mem[kw_rd_addr];
	end

	// entry sum store: restart on position zero, add on other positions
	assign load_base   = sum_valid_q[cur_sidx_q] ? sum_rd_q : '0;
	assign sum_we      = (take && is_load && q_ctl.first) || (state_q == ST_LOAD_ADD);
	assign sum_wr_idx  = (state_q == ST_LOAD_ADD) ? cur_sidx_q : q_sidx;
	assign sum_wr_data = (state_q == ST_LOAD_ADD) ? load_base + SUM_W'(cur_char_q)
	                                              : SUM_W'(q_char);
	assign sum_rd_idx  = (state_q == ST_IDLE) ? q_sidx : e_sidx;

	always_ff @(posedge clk) begin
		if (sum_we) begin
			sum_mem[sum_wr_idx] <= sum_wr_data;
		end
		sum_rd_q <= sum_mem[sum_rd_idx];
	end

	// entry sum valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= '0;
		end else if (sum_we) begin
			sum_valid_q[sum_wr_idx] <= 1'b1;
		end
	end

	// token byte store
	assign tok_we = take && !is_load && q_ctl.store && tok_room;

	always_ff @(posedge clk) begin
		if (tok_we) begin
			tok_mem[tok_len_q[TAW-1:0]] <= q_char;
		end
		tok_rd_q <= tok_mem[i_q[TAW-1:0]];
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tok_len_q   <= '0;
			tok_sum_q   <= '0;
			cur_sidx_q  <= '0;
			cur_char_q  <= '0;
			e_q         <= '0;
			limit_q     <= '0;
			base_q      <= '0;
			i_q         <= '0;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_idx_q   <= '0;
		end else begin
			// result valid: set on emit, cleared once taken
			if ((state_q == ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (is_load) begin
							if (!q_ctl.first) begin
								cur_sidx_q <= q_sidx;
								cur_char_q <= q_char;
								state_q    <= ST_LOAD_ADD;
							end
						end else begin
							if (q_ctl.store && tok_room) begin
								tok_len_q <= tok_len_q + 1'b1;
								tok_sum_q <= tok_sum_q + SUM_W'(q_char);
							end
							if (q_ctl.last) begin
								e_q     <= '0;
								base_q  <= '0;
								limit_q <= limit_ext[EW-1:0];
								state_q <= ST_SEARCH;
							end
						end
					end
				end
				ST_LOAD_ADD: begin
					state_q <= ST_IDLE;
				end
				ST_SEARCH: begin
					i_q <= '0;
					if (e_q == limit_q) begin
						res_found_q <= 1'b0;
						res_idx_q   <= '0;
						state_q     <= ST_EMIT;
					end else begin
						state_q <= ST_SUM_CHK;
					end
				end
				ST_SUM_CHK: begin
					if (entry_sum == tok_sum_q) begin
						state_q <= ST_BYTE_RD;
					end else begin
						e_q     <= e_q + 1'b1;
						base_q  <= base_q + KAW'(STRIDE);
						state_q <= ST_SEARCH;
					end
				end
				ST_BYTE_RD: begin
					state_q <= ST_BYTE_CHK;
				end
				ST_BYTE_CHK: begin
					if (i_q == tok_len_q) begin
						// keyword must end right after the token
						if (kw_rd_q == kwtm_pkg::CHAR_NUL) begin
							res_found_q <= 1'b1;
							res_idx_q   <= e_ext[kwtm_pkg::INDEX_W-1:0];
							state_q     <= ST_EMIT;
						end else begin
							e_q     <= e_q + 1'b1;
							base_q  <= base_q + KAW'(STRIDE);
							state_q <= ST_SEARCH;
						end
					end else if (kw_rd_q == tok_rd_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_BYTE_RD;
					end else begin
						e_q     <= e_q + 1'b1;
						base_q  <= base_q + KAW'(STRIDE);
						state_q <= ST_SEARCH;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_found_q <= res_found_q;
						out_idx_q   <= res_idx_q;
						tok_len_q   <= '0;
						tok_sum_q   <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_valid = out_valid_q;
	assign m_found = out_found_q;
	assign m_index = out_idx_q;

endmodule

`default_nettype wire

FILE: rtl/keyword_table_matcher_core.sv
// top level of the keyword table matcher: config register, front, queue and back
//
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata, tuser (command), tlast
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata (keyword_index), tuser (found)
//  cfg       | in        | cfg_valid / cfg_ready          | cfg_data (keyword_count)
//
// a keyword load at position zero is handled by the back part in idle, at any other position
// it also passes through ST_LOAD_ADD (read, add and write of the entry sum memory); a token
// char is handled in idle. the final token char starts a table walk: ST_SEARCH per entry,
// ST_SUM_CHK for its sum read, ST_BYTE_RD and ST_BYTE_CHK per compared byte (keyword and
// token memory reads); a walk that found nothing closes in ST_SEARCH, then ST_EMIT emits.
// reset clears the entry sums through valid bits, token length and sum; no clearing pass.
// the two-deep queue takes up to two items while the back part searches or waits
// on a result that has not been taken, then the input stalls; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module keyword_table_matcher_core #(
	parameter int MAX_KEYWORDS = kwtm_pkg::MAX_KEYWORDS_DEF,
	parameter int TOKEN_CHARS  = kwtm_pkg::TOKEN_CHARS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // entry_index[5:0], char_position[12:6],
	                                         // char_value[20:13], zero[23:21]
	input  wire logic [0:0]  s_axis_tuser,   // command[0]
	input  wire logic        s_axis_tlast,   // token_last
	// result items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,   // keyword_index[5:0], zero[7:6]
	output logic [0:0]       m_axis_tuser,   // found[0]
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [6:0]  cfg_data        // keyword_count
);

	localparam int STRIDE    = TOKEN_CHARS + 1;
	localparam int KW_DEPTH  = MAX_KEYWORDS * STRIDE;
	localparam int KAW       = $clog2(KW_DEPTH);
	localparam int SUM_DEPTH = (MAX_KEYWORDS < kwtm_pkg::SUM_DEPTH_CAP) ?
	                           MAX_KEYWORDS : kwtm_pkg::SUM_DEPTH_CAP;
	localparam int SAW       = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
	localparam int CTL_W     = $bits(kwtm_pkg::item_ctl_t);
	localparam int QW        = CTL_W + KAW + SAW + kwtm_pkg::CHAR_W;

	logic [kwtm_pkg::COUNT_W-1:0] keyword_count_q;

	logic                          f_push;
	kwtm_pkg::item_ctl_t           f_ctl;
	logic [KAW-1:0]                f_addr;
	logic [SAW-1:0]                f_sidx;
	logic [kwtm_pkg::CHAR_W-1:0]   f_char;
	logic                          q_full;
	logic                          q_empty;
	logic                          q_pop;
	logic [QW-1:0]                 q_data;
	kwtm_pkg::item_ctl_t           b_ctl;
	logic [KAW-1:0]                b_addr;
	logic [SAW-1:0]                b_sidx;
	logic [kwtm_pkg::CHAR_W-1:0]   b_char;
	logic                          out_found;
	logic [kwtm_pkg::INDEX_W-1:0]  out_index;

	// configuration register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keyword_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			keyword_count_q <= cfg_data;
		end
	end

	// front part
	kwtm_front #(
		.MAX_KEYWORDS (MAX_KEYWORDS),
		.TOKEN_CHARS  (TOKEN_CHARS),
		.KAW          (KAW),
		.SAW          (SAW)
	) u_front (
		.s_valid       (s_axis_tvalid),
		.s_ready       (s_axis_tready),
		.command       (s_axis_tuser[0]),
		.entry_index   (s_axis_tdata[5:0]),
		.char_position (s_axis_tdata[12:6]),
		.char_value    (s_axis_tdata[20:13]),
		.token_last    (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (f_push),
		.q_ctl         (f_ctl),
		.q_addr        (f_addr),
		.q_sidx        (f_sidx),
		.q_char        (f_char)
	);

	// queue between the parts
	kwtm_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_ctl, f_addr, f_sidx, f_char}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_data),
		.empty     (q_empty)
	);

	assign {b_ctl, b_addr, b_sidx, b_char} = q_data;

	// back part
	kwtm_back #(
		.MAX_KEYWORDS (MAX_KEYWORDS),
		.TOKEN_CHARS  (TOKEN_CHARS),
		.KAW          (KAW),
		.SAW          (SAW),
		.SUM_DEPTH    (SUM_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.keyword_count (keyword_count_q),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.q_ctl         (b_ctl),
		.q_addr        (b_addr),
		.q_sidx        (b_sidx),
		.q_char        (b_char),
		.m_valid       (m_axis_tvalid),
		.m_ready       (m_axis_tready),
		.m_found       (out_found),
		.m_index       (out_index)
	);

	assign m_axis_tdata = {2'b00, out_index};
	assign m_axis_tuser = out_found;

endmodule

`default_nettype wire

FILE: tb/keyword_table_matcher_core_test.sv
// self-checking testbench for the keyword table matcher core
`timescale 1ns / 1ps

module keyword_table_matcher_core_test;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 6;
	localparam int NUM_ENTRIES   = 64;
	localparam int NAME_BYTES    = 65;
	localparam int TOKEN_MAX     = 64;
	localparam int BUF_BYTES     = 70;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 100000;
	localparam int PHASE_ITEMS   = 45;
	localparam int NUM_PHASES    = 8;

	localparam logic [7:0] LOWER_A  = "a";
	localparam logic [7:0] LOWER_Z  = "z";
	localparam logic [7:0] UPPER_A  = "A";
	localparam logic [7:0] UPPER_Z  = "Z";
	localparam logic [7:0] CASE_GAP = 8'h20;

	// one input item as queued for the driver
	typedef struct packed {
		kwtm_pkg::op_t command;
		logic [5:0]    entry;
		logic [6:0]    pos;
		logic [7:0]    ch;
		logic          last;
	} char_item_t;

	// one lookup result
	typedef struct packed {
		logic       found;
		logic [5:0] index;
	} lookup_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata = '0;   // entry_index[5:0], char_position[12:6],
	                                  // char_value[20:13], zero[23:21]
	logic [0:0]  s_axis_tuser = '0;   // command[0]
	logic        s_axis_tlast = 1'b0; // token_last
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;        // keyword_index[5:0], zero[7:6]
	logic [0:0]  m_axis_tuser;        // found[0]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;       // keyword_count

	keyword_table_matcher_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// predicted table and token state
	logic [7:0]  kw_text [NUM_ENTRIES][NAME_BYTES];
	logic [15:0] kw_sum [NUM_ENTRIES];
	logic [7:0]  tok_text [TOKEN_MAX];
	int          tok_len = 0;
	logic [15:0] tok_sum = '0;
	logic [6:0]  kw_limit = '0;
	lookup_t     lookup_q[$];

	// stimulus side: what each entry holds and where its terminator sits
	logic [7:0]  gen_word [NUM_ENTRIES][NAME_BYTES];
	int          gen_term [NUM_ENTRIES];
	logic [7:0]  wbuf [BUF_BYTES];
	int          wlen;
	char_item_t  item_fifo[$];

	int queued_items = 0;
	int accepted_items = 0;
	int error_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic in_taken = 1'b0;

	function automatic logic [7:0] to_upper(input logic [7:0] c);
		return (c >= LOWER_A && c <= LOWER_Z) ? c - CASE_GAP : c;
	endfunction

	function automatic bit entry_matches(input int e);
		int i;
		if (kw_sum[e] != tok_sum)
			return 1'b0;
		for (i = 0; i < tok_len; i++)
			if (kw_text[e][i] != tok_text[i])
				return 1'b0;
		return kw_text[e][tok_len] == kwtm_pkg::CHAR_NUL;
	endfunction

	// update the predicted state with one accepted item
	task automatic take_item(input logic [23:0] d, input kwtm_pkg::op_t cmd, input logic last);
		logic [5:0] e;
		logic [6:0] p;
		logic [7:0] c;
		int limit, idx;
		lookup_t res;
		e = d[5:0];
		p = d[12:6];
		c = d[20:13];
		if (cmd == kwtm_pkg::OP_LOAD) begin
			if (p <= TOKEN_MAX) begin
				kw_text[e][p] = c;
				kw_sum[e] = (p == 0) ? {8'h00, c} : kw_sum[e] + c;
			end
		end else begin
			if (c != kwtm_pkg::CHAR_NUL && tok_len < TOKEN_MAX) begin
				tok_text[tok_len] = to_upper(c);
				tok_sum = tok_sum + to_upper(c);
				tok_len++;
			end
			if (last) begin
				limit = (kw_limit > NUM_ENTRIES) ? NUM_ENTRIES : kw_limit;
				res = '0;
				for (idx = 0; idx < limit && !res.found; idx++)
					if (entry_matches(idx)) begin
						res.found = 1'b1;
						res.index = idx[5:0];
					end
				lookup_q.push_back(res);
				tok_len = 0;
				tok_sum = '0;
			end
		end
	endtask

	// sample both channels, predict, check and watch for a hang
	always @(posedge clk) begin
		lookup_t want;
		if (arst_n) begin
			in_taken <= s_axis_tvalid && s_axis_tready;
			if (s_axis_tvalid && s_axis_tready) begin
				accepted_items++;
				take_item(s_axis_tdata, kwtm_pkg::op_t'(s_axis_tuser[0]), s_axis_tlast);
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (lookup_q.size() == 0) begin
					$error("result with nothing pending: found %0d keyword_index %0d",
						m_axis_tuser[0], m_axis_tdata[5:0]);
					error_count++;
				end else begin
					want = lookup_q.pop_front();
					if (m_axis_tuser[0] !== want.found) begin
						$error("found: expected %0d, got %0d", want.found, m_axis_tuser[0]);
						error_count++;
					end
					if (m_axis_tdata[5:0] !== want.index) begin
						$error("keyword_index: expected %0d, got %0d",
							want.index, m_axis_tdata[5:0]);
						error_count++;
					end
				end
			end
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// drive the next item and the result back-pressure
	always @(negedge clk) begin
		char_item_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else if (!s_axis_tvalid || in_taken) begin
			if (item_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				it = item_fifo.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {3'b000, it.ch, it.pos, it.entry};
				s_axis_tuser  <= it.command;
				s_axis_tlast  <= it.last;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	task automatic push_item(input kwtm_pkg::op_t cmd, input int e, input int p,
			input logic [7:0] c, input logic last);
		char_item_t it;
		it.command = cmd;
		it.entry   = e[5:0];
		it.pos     = p[6:0];
		it.ch      = c;
		it.last    = last;
		item_fifo.push_back(it);
		queued_items++;
	endtask

	// token items carry random don't-care entry and position fields
	task automatic push_token(input logic [7:0] c, input logic last);
		push_item(kwtm_pkg::OP_TOKEN, $urandom_range(63), $urandom_range(127), c, last);
	endtask

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return 8'(UPPER_A + $urandom_range(25));
		else if (r < 8)
			return 8'("0" + $urandom_range(9));
		else if (r == 8)
			return 8'(LOWER_A + $urandom_range(25));
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic void set_text(input string s);
		int i;
		wlen = s.len();
		for (i = 0; i < wlen; i++)
			wbuf[i] = s[i];
	endfunction

	// write wbuf into an entry, optionally with position zero written last
	task automatic store_word(input int e, input bit terminated, input bit shuffle);
		int i;
		bit zero_last;
		zero_last = shuffle && wlen > 1 && $urandom_range(9) == 0;
		for (i = zero_last ? 1 : 0; i < wlen; i++)
			push_item(kwtm_pkg::OP_LOAD, e, i, wbuf[i], 1'($urandom_range(1)));
		if (terminated)
			push_item(kwtm_pkg::OP_LOAD, e, wlen, kwtm_pkg::CHAR_NUL, 1'($urandom_range(1)));
		if (zero_last)
			push_item(kwtm_pkg::OP_LOAD, e, 0, wbuf[0], 1'($urandom_range(1)));
		for (i = 0; i < wlen; i++)
			gen_word[e][i] = wbuf[i];
		if (terminated)
			gen_word[e][wlen] = kwtm_pkg::CHAR_NUL;
		gen_term[e] = terminated ? wlen : NAME_BYTES;
	endtask

	task automatic random_word();
		int i;
		wlen = ($urandom_range(19) == 0) ? TOKEN_MAX : $urandom_range(1, 8);
		for (i = 0; i < wlen; i++)
			wbuf[i] = pick_char();
	endtask

	// stray zero chars are mixed in now and then; they must be ignored
	task automatic send_token();
		int i;
		if (wlen == 0)
			push_token(kwtm_pkg::CHAR_NUL, 1'b1);
		for (i = 0; i < wlen; i++) begin
			if ($urandom_range(19) == 0)
				push_token(kwtm_pkg::CHAR_NUL, 1'b0);
			push_token(wbuf[i], i == wlen - 1);
		end
	endtask

	// token built from an entry: mixed case, sometimes altered or overlong
	task automatic token_from_entry(input int e, input bit stretch);
		int i, n;
		wlen = gen_term[e];
		for (i = 0; i < wlen; i++) begin
			wbuf[i] = gen_word[e][i];
			if (wbuf[i] >= UPPER_A && wbuf[i] <= UPPER_Z && $urandom_range(1))
				wbuf[i] = wbuf[i] + CASE_GAP;
		end
		if (stretch || (wlen >= TOKEN_MAX && $urandom_range(1))) begin
			n = $urandom_range(1, 3);
			for (i = 0; i < n; i++) begin
				wbuf[wlen] = pick_char();
				wlen++;
			end
		end else if ($urandom_range(4) == 0) begin
			case ($urandom_range(2))
			0: if (wlen > 0) wbuf[$urandom_range(wlen - 1)] = pick_char();
			1: begin
				wbuf[wlen] = pick_char();
				wlen++;
			end
			default: if (wlen > 0) wlen--;
			endcase
		end
		send_token();
	endtask

	task automatic noise_token();
		int i;
		wlen = ($urandom_range(15) == 0) ? $urandom_range(60, 69) : $urandom_range(10);
		for (i = 0; i < wlen; i++)
			wbuf[i] = 8'($urandom_range(255));
		send_token();
	endtask

	// random load that never leaves a searched entry without a written terminator
	task automatic noise_load();
		int e, p;
		logic [7:0] c;
		e = $urandom_range(63);
		p = ($urandom_range(4) == 0) ? $urandom_range(65, 127) : $urandom_range(64);
		c = 8'($urandom_range(255));
		if (p <= TOKEN_MAX) begin
			if (p == gen_term[e])
				c = kwtm_pkg::CHAR_NUL;
			gen_word[e][p] = c;
			if (c == kwtm_pkg::CHAR_NUL && p < gen_term[e])
				gen_term[e] = p;
		end
		push_item(kwtm_pkg::OP_LOAD, e, p, c, 1'($urandom_range(1)));
	endtask

	// wait until all items are taken and all results are back, then let loads drain
	task automatic wait_quiet();
		while (accepted_items != queued_items || lookup_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_count(input logic [6:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		kw_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [6:0] count, input int idle_pct, input int stall_pct);
		int start, r, e, reach;
		wait_quiet();
		write_count(count);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		reach = (count > NUM_ENTRIES) ? NUM_ENTRIES : count;
		start = queued_items;
		while (queued_items - start < PHASE_ITEMS) begin
			r = $urandom_range(99);
			if (r < 10) begin
				noise_load();
			end else if (r < 22) begin
				random_word();
				store_word($urandom_range(63), 1'b1, 1'b1);
			end else if (r < 80) begin
				if (reach > 0 && reach < NUM_ENTRIES && $urandom_range(9) < 7)
					e = $urandom_range(reach - 1);
				else
					e = $urandom_range(63);
				token_from_entry(e, 1'b0);
			end else begin
				noise_token();
			end
		end
	endtask

	initial begin
		int e, i, ph;
		int idle_mode [4];
		int stall_mode [4];
		logic [6:0] phase_count [NUM_PHASES];
		idle_mode  = '{0, 52, 0, 12};
		stall_mode = '{0, 0, 52, 12};
		phase_count = '{7'd64, 7'd127, 7'd0, 7'd1, 7'd33, 7'd65, 7'd64, 7'd20};
		phase_count[NUM_PHASES - 1] = 7'($urandom_range(2, 63));
		for (e = 0; e < NUM_ENTRIES; e++) begin
			kw_sum[e] = '0;
			for (i = 0; i < NAME_BYTES; i++)
				kw_text[e][i] = '0;
		end

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill every entry with a short word so no search ever reads an unwritten byte
		for (e = 0; e < NUM_ENTRIES; e++) begin
			wlen = $urandom_range(1, 2);
			for (i = 0; i < wlen; i++)
				wbuf[i] = pick_char();
			store_word(e, 1'b1, 1'b1);
		end
		set_text("abc");
		store_word(2, 1'b1, 1'b0);
		set_text("BB");
		store_word(3, 1'b1, 1'b0);
		set_text("");
		store_word(5, 1'b1, 1'b0);
		set_text("CAT");
		store_word(7, 1'b1, 1'b0);
		set_text("`AZ{");
		store_word(9, 1'b1, 1'b0);
		wlen = TOKEN_MAX;
		for (i = 0; i < wlen; i++)
			wbuf[i] = 8'(UPPER_A + $urandom_range(25));
		store_word(12, 1'b1, 1'b0);
		// entry without terminator, every position holds a nonzero byte
		wlen = NAME_BYTES;
		for (i = 0; i < wlen; i++)
			wbuf[i] = pick_char();
		store_word(13, 1'b0, 1'b0);
		set_text("DUP");
		store_word(20, 1'b1, 1'b0);
		store_word(41, 1'b1, 1'b0);
		set_text("LAST");
		store_word(63, 1'b1, 1'b0);
		wait_quiet();
		write_count(7'd64);

		// directed: empty token, folding, zero char, sum collision, duplicates
		set_text("");
		send_token();
		set_text("cat");
		send_token();
		push_token("C", 1'b0);
		push_token(kwtm_pkg::CHAR_NUL, 1'b0);
		push_token("A", 1'b0);
		push_token("T", 1'b1);
		set_text("AC");
		send_token();
		set_text("`az{");
		send_token();
		set_text("dup");
		send_token();
		set_text("abc");
		send_token();
		// loads past the last position are dropped
		push_item(kwtm_pkg::OP_LOAD, 7, 100, "X", 1'b0);
		push_item(kwtm_pkg::OP_LOAD, 7, 127, 8'hff, 1'b1);
		set_text("LAST");
		send_token();
		// overlong token whose kept chars equal the full-length entry
		token_from_entry(12, 1'b1);

		for (ph = 0; ph < NUM_PHASES; ph++)
			run_phase(phase_count[ph], idle_mode[ph % 4], stall_mode[ph % 4]);
		wait_quiet();

		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
